### src/isotp_pkg.sv
// ----------------------------------------------------------------------------
// isotp_pkg: shared types and constants for the ISO-TP frame segmenter
// Header codes, frame capacities and the structs that pass between the
// segmenter state logic and the top level.
// ----------------------------------------------------------------------------
package isotp_pkg;

   localparam logic [7:0] FF_HEADER   = 8'h10;
   localparam logic [7:0] CF_HEADER   = 8'h20;
   localparam logic [3:0] SEQ_FIRST   = 4'h1;
   localparam logic [2:0] FF_CAPACITY = 3'd6;
   localparam logic [2:0] CF_CAPACITY = 3'd7;
   localparam logic [7:0] PAD_BYTE    = 8'h00;
   localparam int unsigned STORE_BYTES = 7;

   // Segmenter state carried from one payload byte to the next
   typedef struct packed {
      logic [8*STORE_BYTES-1:0] store;   // frame bytes 1..7, byte 1 in the low bits
      logic [2:0]               fill;    // payload bytes placed in the open frame
      logic [7:0]               taken;   // payload bytes taken for the message
      logic [7:0]               length;  // latched message length
      logic [10:0]              id;      // latched CAN identifier
      logic [3:0]               seq;     // sequence number of the next CF
      logic                     first;   // open frame is the first frame
   } seg_state_type;

   // One complete CAN frame, data[0] is the control header
   typedef struct packed {
      logic [10:0]     frame_id;
      logic [7:0][7:0] data;
      logic            last;
   } frame_type;

endpackage

### src/isotp_seg_step.sv
// ----------------------------------------------------------------------------
// isotp_seg_step: next-state and frame logic for one payload byte
// Places the byte into the open frame, decides whether the frame is complete
// and builds the outgoing frame. Purely combinational.
// ----------------------------------------------------------------------------
module isotp_seg_step (
   input  isotp_pkg::seg_state_type state_cur,
   input  logic [10:0]              in_can_id,
   input  logic [7:0]               in_message_length,
   input  logic [7:0]               in_data_byte,
   input  logic                     in_start_of_message,
   output isotp_pkg::seg_state_type state_nxt,
   output logic                     emit,
   output isotp_pkg::frame_type     frame
);

   isotp_pkg::seg_state_type base;
   isotp_pkg::seg_state_type added;
   logic                     closed;
   logic                     take;
   logic [3:0]               pos_wide;
   logic [2:0]               pos;
   logic [2:0]               cap;

   always_comb begin
      // restart the message on a start byte
      base = state_cur;
      if (in_start_of_message) begin
         base.id     = in_can_id;
         base.length = in_message_length;
         base.taken  = '0;
         base.fill   = '0;
         base.store  = '0;
         base.seq    = isotp_pkg::SEQ_FIRST;
         base.first  = 1'b1;
      end

      closed = (base.taken >= base.length);
      take   = !closed;

      // byte position inside frame bytes 1..7
      pos_wide = {1'b0, base.fill} + {3'b000, base.first};
      pos      = (pos_wide > 4'd6) ? 3'd6 : pos_wide[2:0];

      added = base;
      if (take) begin
         for (int k = 0; k < isotp_pkg::STORE_BYTES; k++) begin
            if (pos == 3'(k)) begin
               added.store[8*k +: 8] = base.store[8*k +: 8] | in_data_byte;
            end
         end
         added.fill  = base.fill + 3'd1;
         added.taken = base.taken + 8'd1;
      end

      cap  = base.first ? isotp_pkg::FF_CAPACITY : isotp_pkg::CF_CAPACITY;
      emit = (in_start_of_message && closed) ||
             (take && ((added.taken >= added.length) || (added.fill >= cap)));

      // build the frame from the updated store
      frame.frame_id = added.id;
      if (added.first) begin
         frame.data[0] = isotp_pkg::FF_HEADER;
         frame.data[1] = added.length;
      end else begin
         frame.data[0] = isotp_pkg::CF_HEADER | {4'h0, added.seq};
         frame.data[1] = added.store[7:0];
      end
      for (int k = 2; k < 8; k++) begin
         frame.data[k] = added.store[8*(k-1) +: 8];
      end
      frame.last = (added.taken >= added.length);

      // close the frame once it goes out
      state_nxt = added;
      if (emit) begin
         if (!added.first) begin
            state_nxt.seq = added.seq + 4'd1;
         end
         state_nxt.first = 1'b0;
         state_nxt.store = {isotp_pkg::STORE_BYTES{isotp_pkg::PAD_BYTE}};
         state_nxt.fill  = '0;
      end
   end

endmodule

### src/isotp_frame_segmenter.sv
// ----------------------------------------------------------------------------
// isotp_frame_segmenter: ISO-TP transmit segmentation into CAN frames
// Packs a byte stream into first and consecutive frames with zero padding.
// ----------------------------------------------------------------------------
// Usage: feed one payload byte per req transfer; set req_start_of_message on
// the first byte of a message together with its CAN identifier and length.
// The block always sends a first frame (0x10, length, up to 6 bytes) and then
// consecutive frames (0x20 | sequence, up to 7 bytes, sequence 1..15, 0, ...),
// padding unused bytes with zero and flagging the final frame on
// rsp_last_frame. A start byte in the middle of a message drops the open
// message; a start byte with length zero sends a lone first frame at once.
// Bytes arriving with no open message are dropped. Throughput is one byte per
// clock unless the stall below holds it: a byte is registered at the input,
// runs through the combinational state update, and a finished frame lands in
// the output register that drives rsp_valid. The only stall comes from
// rsp_ready: a frame-completing byte waits while the output register holds
// an untaken frame.
// ----------------------------------------------------------------------------
module isotp_frame_segmenter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [10:0] req_can_id,
   input  logic [7:0]  req_message_length,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_frame_id,
   output logic [7:0]  rsp_byte_0,
   output logic [7:0]  rsp_byte_1,
   output logic [7:0]  rsp_byte_2,
   output logic [7:0]  rsp_byte_3,
   output logic [7:0]  rsp_byte_4,
   output logic [7:0]  rsp_byte_5,
   output logic [7:0]  rsp_byte_6,
   output logic [7:0]  rsp_byte_7,
   output logic        rsp_last_frame
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [10:0] in_can_id_ff;
   logic [7:0]  in_length_ff;
   logic [7:0]  in_data_ff;
   logic        in_sof_ff;

   // segmenter state
   isotp_pkg::seg_state_type state_ff, state_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   isotp_pkg::frame_type out_frame_ff;

   // step logic results
   logic                 emit;
   isotp_pkg::frame_type frame;
   logic                 advance;

   isotp_seg_step u_step (
      .state_cur           (state_ff),
      .in_can_id           (in_can_id_ff),
      .in_message_length   (in_length_ff),
      .in_data_byte        (in_data_ff),
      .in_start_of_message (in_sof_ff),
      .state_nxt           (state_in),
      .emit                (emit),
      .frame               (frame)
   );

   // A registered byte advances unless it completes a frame while the
   // output register is still full and not being drained.
   assign advance     = in_valid_ff && (!emit || !out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{store:  '0,
                           fill:   '0,
                           taken:  '0,
                           length: '0,
                           id:     '0,
                           seq:    isotp_pkg::SEQ_FIRST,
                           first:  1'b1};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers: capture on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_can_id_ff <= req_can_id;
         in_length_ff <= req_message_length;
         in_data_ff   <= req_data_byte;
         in_sof_ff    <= req_start_of_message;
      end
      if (advance && emit) begin
         out_frame_ff <= frame;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_frame_id   = out_frame_ff.frame_id;
   assign rsp_byte_0     = out_frame_ff.data[0];
   assign rsp_byte_1     = out_frame_ff.data[1];
   assign rsp_byte_2     = out_frame_ff.data[2];
   assign rsp_byte_3     = out_frame_ff.data[3];
   assign rsp_byte_4     = out_frame_ff.data[4];
   assign rsp_byte_5     = out_frame_ff.data[5];
   assign rsp_byte_6     = out_frame_ff.data[6];
   assign rsp_byte_7     = out_frame_ff.data[7];
   assign rsp_last_frame = out_frame_ff.last;

   // an open frame never holds as many bytes as it can carry
   a_fill_below_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff.fill < (state_ff.first ? isotp_pkg::FF_CAPACITY : isotp_pkg::CF_CAPACITY))
      else $error("open frame fill reached its capacity");

   // never take more bytes than the message length
   a_taken_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.taken <= state_ff.length)
      else $error("bytes taken exceed message length");

   // frame byte 1 of a first frame is the length, never payload
   a_ff_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff.first |-> (state_ff.store[7:0] == isotp_pkg::PAD_BYTE))
      else $error("payload written to length slot of first frame");

   // a completed frame shows up on the output next cycle
   a_emit_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> (rsp_valid && (rsp_byte_0 == $past(frame.data[0]))))
      else $error("completed frame did not reach the output register");

endmodule

### tb/isotp_frame_segmenter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_frame_segmenter_tb: self-checking regression for the ISO-TP segmenter
// Streams payload bytes into the segmenter and predicts every CAN frame it
// should send (first frame, consecutive frames with wrapping sequence, zero
// padding, last-frame flag). Each frame is checked field by field in order.
// Covers stray bytes, zero-length starts, restarts and long wrapping messages,
// with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module isotp_frame_segmenter_tb;

   localparam int CLK_HIGH           = 6;
   localparam int CLK_LOW            = 6;
   localparam int RESET_CYCLES       = 7;
   localparam int DRAIN_LIMIT        = 5000;
   localparam int TAIL_CYCLES        = 8;
   localparam int MISMATCH_PRINT_MAX = 20;
   localparam int RANDOM_BYTES       = 330;
   localparam int QUIET_BYTES        = 150;

   typedef enum {MSG_FULL, MSG_TRUNCATED, MSG_ZERO_LENGTH, MSG_STRAY_BYTE} msg_kind_type;

   // DUT ports; every input starts at a known value
   logic        clock                = 1'b0;
   logic        reset                = 1'b1;
   logic        req_valid            = 1'b0;
   logic        req_ready;
   logic [10:0] req_can_id           = '0;
   logic [7:0]  req_message_length   = '0;
   logic [7:0]  req_data_byte        = '0;
   logic        req_start_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready            = 1'b0;
   logic [10:0] rsp_frame_id;
   logic [7:0]  rsp_byte_0, rsp_byte_1, rsp_byte_2, rsp_byte_3;
   logic [7:0]  rsp_byte_4, rsp_byte_5, rsp_byte_6, rsp_byte_7;
   logic        rsp_last_frame;

   // Predicted segmenter state, mirrors the block's reset values
   logic [55:0] seg_store  = '0;
   logic [2:0]  seg_fill   = '0;
   logic [7:0]  seg_taken  = '0;
   logic [7:0]  seg_length = '0;
   logic [10:0] seg_id     = '0;
   logic [3:0]  seg_seq    = isotp_pkg::SEQ_FIRST;
   logic        seg_first  = 1'b1;

   isotp_pkg::frame_type frames_due[$];
   isotp_pkg::frame_type got_frame;
   isotp_pkg::frame_type want_frame;

   int mismatches       = 0;
   int frames_checked   = 0;
   int bytes_consumed   = 0;
   int bytes_dropped    = 0;
   int restarts         = 0;
   int zero_length_msgs = 0;
   bit gaps_on          = 1'b1;
   int gap_odds         = 0;
   int rsp_hold         = 0;

   isotp_frame_segmenter uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_can_id           (req_can_id),
      .req_message_length   (req_message_length),
      .req_data_byte        (req_data_byte),
      .req_start_of_message (req_start_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_frame_id         (rsp_frame_id),
      .rsp_byte_0           (rsp_byte_0),
      .rsp_byte_1           (rsp_byte_1),
      .rsp_byte_2           (rsp_byte_2),
      .rsp_byte_3           (rsp_byte_3),
      .rsp_byte_4           (rsp_byte_4),
      .rsp_byte_5           (rsp_byte_5),
      .rsp_byte_6           (rsp_byte_6),
      .rsp_byte_7           (rsp_byte_7),
      .rsp_last_frame       (rsp_last_frame)
   );

   always begin
      #CLK_HIGH clock = 1'b1;
      #CLK_LOW  clock = 1'b0;
   end

   // Guard against a hung handshake
   initial begin
      #5_000_000;
      $display("isotp_frame_segmenter regression: fail");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      if (mismatches < MISMATCH_PRINT_MAX)
         $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // Close the open frame: build what the block should send, queue it, and
   // advance to the next consecutive frame.
   function automatic void close_frame();
      isotp_pkg::frame_type f;
      f.frame_id = seg_id;
      if (seg_first) begin
         f.data[0] = isotp_pkg::FF_HEADER;
         f.data[1] = seg_length;
      end else begin
         f.data[0] = isotp_pkg::CF_HEADER | {4'h0, seg_seq};
         f.data[1] = seg_store[7:0];
      end
      for (int k = 1; k < 7; k++)
         f.data[k+1] = seg_store[8*k +: 8];
      f.last = (seg_taken >= seg_length);
      frames_due.push_back(f);
      if (!seg_first)
         seg_seq = seg_seq + 4'd1;
      seg_first = 1'b0;
      seg_store = '0;
      seg_fill  = '0;
   endfunction

   // Predict the effect of one accepted payload transfer
   function automatic void segment_byte(input logic [10:0] id, input logic [7:0] len,
                                        input logic [7:0] data, input logic sof);
      int unsigned pos;
      logic [2:0]  cap;
      if (sof) begin
         if (seg_taken < seg_length)
            restarts++;
         seg_id     = id;
         seg_length = len;
         seg_taken  = '0;
         seg_fill   = '0;
         seg_store  = '0;
         seg_seq    = isotp_pkg::SEQ_FIRST;
         seg_first  = 1'b1;
         bytes_consumed++;
         if (len == 8'd0) begin
            // lone first frame, the data byte is dropped
            zero_length_msgs++;
            close_frame();
            return;
         end
      end else if (seg_taken >= seg_length) begin
         // no open message: the byte is dropped
         bytes_dropped++;
         return;
      end else begin
         bytes_consumed++;
      end
      pos = (seg_first ? 1 : 0) + seg_fill;
      if (pos > 6)
         pos = 6;
      seg_store = seg_store | (56'(data) << (8 * pos));
      seg_fill  = seg_fill + 3'd1;
      seg_taken = seg_taken + 8'd1;
      cap = seg_first ? isotp_pkg::FF_CAPACITY : isotp_pkg::CF_CAPACITY;
      if (seg_taken >= seg_length || seg_fill >= cap)
         close_frame();
   endfunction

   // Send one byte: maybe idle first, hold valid until the transfer, then predict.
   // Valid stays high on return so back-to-back bytes need no second update.
   task automatic send_byte(input logic [10:0] id, input logic [7:0] len,
                            input logic [7:0] data, input logic sof);
      if (gaps_on && gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_can_id           <= id;
      req_message_length   <= len;
      req_data_byte        <= data;
      req_start_of_message <= sof;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      segment_byte(id, len, data, sof);
   endtask

   // Start byte with id and length, then n_bytes-1 more; fill_value < 0 means
   // random data. Fields that only matter on the start byte get random values.
   task automatic send_message(input logic [10:0] id, input logic [7:0] len,
                               input int n_bytes, input int fill_value);
      logic [7:0] data;
      for (int i = 0; i < n_bytes; i++) begin
         data = (fill_value < 0) ? 8'($urandom_range(0, 255)) : 8'(fill_value);
         if (i == 0)
            send_byte(id, len, data, 1'b1);
         else
            send_byte(11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)), data, 1'b0);
      end
   endtask

   function automatic logic [7:0] random_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return 8'($urandom_range(1, 30));
      else if (r < 95)
         return 8'($urandom_range(31, 120));
      return 8'($urandom_range(121, 255));
   endfunction

   // Response side: drop rsp_ready in random bursts while gaps are on
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
         rsp_hold  <= $urandom_range(1, 8) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Frame checker: compare every transfer on rsp with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_frame.frame_id = rsp_frame_id;
         got_frame.data     = {rsp_byte_7, rsp_byte_6, rsp_byte_5, rsp_byte_4,
                               rsp_byte_3, rsp_byte_2, rsp_byte_1, rsp_byte_0};
         got_frame.last     = rsp_last_frame;
         if (frames_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected frame id %03h header %02h",
                                    got_frame.frame_id, got_frame.data[0]));
         end else begin
            want_frame = frames_due.pop_front();
            frames_checked++;
            if (got_frame.frame_id !== want_frame.frame_id)
               flag_mismatch($sformatf("frame %0d frame_id got %03h want %03h",
                             frames_checked, got_frame.frame_id, want_frame.frame_id));
            for (int k = 0; k < 8; k++)
               if (got_frame.data[k] !== want_frame.data[k])
                  flag_mismatch($sformatf("frame %0d byte_%0d got %02h want %02h",
                                frames_checked, k, got_frame.data[k], want_frame.data[k]));
            if (got_frame.last !== want_frame.last)
               flag_mismatch($sformatf("frame %0d last_frame got %0b want %0b",
                             frames_checked, got_frame.last, want_frame.last));
         end
      end
   end

   // Stray bytes around reset and after a finished message, zero-length start,
   // and a one-byte message
   task automatic test_idle_and_zero_length();
      gap_odds = 20;
      send_byte(11'h7FF, 8'hFF, 8'hFF, 1'b0);
      send_message(11'h7FF, 8'd0, 1, 8'hFF);
      send_byte(11'h000, 8'h00, 8'h00, 1'b0);
      send_message(11'h000, 8'd1, 1, 8'hFF);
   endtask

   // Exactly full first frame, then first frame plus a one-byte consecutive frame
   task automatic test_frame_boundaries();
      gap_odds = 0;
      send_message(11'h2A5, 8'd6, 6, -1);
      send_message(11'h55A, 8'd7, 7, 8'hFF);
   endtask

   // Abandon a message with a new start byte, and with a zero-length start
   task automatic test_restart();
      gap_odds = 25;
      send_message(11'h123, 8'd20, 3, -1);
      send_message(11'h456, 8'd3, 3, -1);
      send_message(11'h789, 8'd9, 2, -1);
      send_message(11'h3C3, 8'd0, 1, 8'h00);
   endtask

   // Long messages: the sequence number runs past 15 and wraps to 0
   task automatic test_sequence_wrap();
      gap_odds = 10;
      send_message(11'h7FF, 8'd255, 255, -1);
      send_message(11'h000, 8'd118, 118, -1);
   endtask

   // Mostly well-formed messages with random content; the rest is truncated
   // messages, zero-length starts and stray bytes
   task automatic test_random_traffic(input int target);
      int           goal;
      msg_kind_type kind;
      int           r;
      logic [7:0]   len;
      goal = bytes_consumed + target;
      while (bytes_consumed < goal) begin
         r = $urandom_range(0, 99);
         if (r < 6)       kind = MSG_STRAY_BYTE;
         else if (r < 14) kind = MSG_TRUNCATED;
         else if (r < 20) kind = MSG_ZERO_LENGTH;
         else             kind = MSG_FULL;
         // some messages go without any sender gaps
         gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
         case (kind)
            MSG_STRAY_BYTE: begin
               send_byte(11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 1'b0);
            end
            MSG_TRUNCATED: begin
               len = 8'($urandom_range(2, 60));
               send_message(11'($urandom_range(0, 2047)), len,
                            $urandom_range(1, len - 1), -1);
            end
            MSG_ZERO_LENGTH: begin
               send_message(11'($urandom_range(0, 2047)), 8'd0, 1, -1);
            end
            default: begin
               len = random_length();
               send_message(11'($urandom_range(0, 2047)), len, len, -1);
            end
         endcase
      end
   endtask

   // Hold off the sender until every predicted frame has come out, then resume
   task automatic test_drain_pause();
      test_random_traffic(100);
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_due.size() != 0)
         @(posedge clock);
      test_random_traffic(100);
   endtask

   // Closing stretch at full rate on both sides
   task automatic test_full_rate();
      gaps_on = 1'b0;
      test_random_traffic(QUIET_BYTES);
   endtask

   initial begin
      int waited;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_and_zero_length();
      test_frame_boundaries();
      test_restart();
      test_sequence_wrap();
      test_random_traffic(RANDOM_BYTES);
      test_drain_pause();
      test_full_rate();

      // Drain: wait for the outstanding frames, then watch for stragglers
      req_valid <= 1'b0;
      waited = 0;
      while (frames_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (frames_due.size() != 0)
         flag_mismatch($sformatf("%0d predicted frames never came out", frames_due.size()));

      $display("Covered %0d payload transfers and %0d dropped stray bytes; %0d frames checked.",
               bytes_consumed, bytes_dropped, frames_checked);
      $display("Included %0d abandoned messages and %0d zero-length starts; %0d mismatches.",
               restarts, zero_length_msgs, mismatches);
      if (mismatches == 0)
         $display("isotp_frame_segmenter regression: pass");
      else
         $display("isotp_frame_segmenter regression: fail");
      $finish;
   end

endmodule
